>>> design/tpbp_pkg.sv
// ----------------------------------------------------------------------------
// tpbp_pkg
// Shared types and constants for the three-port bit-plane PWM unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpbp_pkg;

  // Three ports of eight pins each; one pattern row holds all three bytes.
  localparam int unsigned NUM_PORTS = 3;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned ROW_W     = NUM_PORTS * PORT_W;
  localparam int unsigned BIT_SEL_W = 5;

  // Item commands.
  localparam logic CMD_SET_DUTY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Highest valid port number and first pin number out of range.
  localparam logic [3:0] PORT_MAX  = 4'd2;
  localparam logic [3:0] PIN_LIMIT = 4'd8;

  typedef logic [PORT_W-1:0] port_byte_t;

  // Control of the pattern store for one cycle.
  typedef struct packed {
    logic                 clr;      // write a zero row
    logic                 wr_bit;   // write a single bit of a row
    logic                 rd;       // read a row into the output register
    logic                 bit_val;  // value for a single-bit write
    logic [BIT_SEL_W-1:0] bit_sel;  // port * 8 + pin
  } store_ctl_t;

  // Control of the slot sweep unit.
  typedef struct packed {
    logic start;  // reset the slot index and load a new duty
    logic step;   // advance the slot index
  } sweep_ctl_t;

endpackage : tpbp_pkg

`default_nettype wire

>>> design/tpbp_store.sv
// ----------------------------------------------------------------------------
// tpbp_store
// Bit-plane pattern memory: one row per time slot, one byte per port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbp_store #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned AW         = 4
) (
  input  wire                      clk,
  input  tpbp_pkg::store_ctl_t     ctl,
  input  wire [AW-1:0]             waddr,
  input  wire [AW-1:0]             raddr,
  output logic [tpbp_pkg::ROW_W-1:0] rdata
);

  logic [tpbp_pkg::ROW_W-1:0] mem [SLOT_COUNT];
  logic [tpbp_pkg::ROW_W-1:0] rdata_r;

  // Whole-row clear, single-bit write and registered row read.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[waddr] <= '0;
    end else if (ctl.wr_bit) begin
      mem[waddr][ctl.bit_sel] <= ctl.bit_val;
    end
    if (ctl.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : tpbp_store

`default_nettype wire

>>> design/tpbp_sweep.sv
// ----------------------------------------------------------------------------
// tpbp_sweep
// Slot index counter with the shared duty compare used by every sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbp_sweep #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned AW         = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tpbp_pkg::sweep_ctl_t  ctl,
  input  wire [7:0]             duty,
  output logic [AW-1:0]         idx,
  output logic                  on,
  output logic                  last
);

  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_nxt;
  logic [7:0]    duty_r;

  // Index steps once per cycle of a sweep and restarts at zero.
  always_comb begin
    idx_nxt = idx_r;
    if (ctl.start) begin
      idx_nxt = '0;
    end else if (ctl.step) begin
      idx_nxt = last ? '0 : idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // The duty needs no reset; it is loaded before each sweep that uses it.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      duty_r <= duty;
    end
  end

  // A slot below the duty is on. Slots never exceed the slot count, so a
  // larger duty behaves as if clamped to it.
  assign on   = (8'(idx_r) < duty_r);
  assign last = (idx_r == AW'(SLOT_COUNT - 1));
  assign idx  = idx_r;

endmodule : tpbp_sweep

`default_nettype wire

>>> design/three_port_bitplane_pwm_unit.sv
// ----------------------------------------------------------------------------
// three_port_bitplane_pwm_unit
// Software PWM for three 8-pin ports held as a bit-plane pattern store.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_cmd, in_port_index, in_pin_index, in_duty) transfer on
//   in_valid with in_stall low; results transfer on out_valid with out_stall
//   low. Each item gives exactly one result.
//   A tick reads the pattern row of the current slot and shows each port's
//   byte masked by its drive mask, then advances the slot.
//   A set-duty item writes the pin's bit in every slot row, one row a cycle
//   through the shared slot counter and duty compare. A bad port or a pin
//   of 8 or more writes nothing and goes straight to the post state.
//   The block takes one item at a time; in_stall is high while it works.
//   A result that is stalled is held in the output register; a new item
//   may be taken meanwhile, and its result waits until the register frees.
//   After reset the pattern store is cleared, one row a cycle, and no
//   item is taken until every row is clear.
// ----------------------------------------------------------------------------
`default_nettype none

module three_port_bitplane_pwm_unit #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  // Input channel.
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_cmd,
  input  wire [3:0]  in_port_index,
  input  wire [3:0]  in_pin_index,
  input  wire [7:0]  in_duty,
  // Result channel.
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_status,
  output logic [7:0] out_port_a_level,
  output logic [7:0] out_port_a_drive,
  output logic [7:0] out_port_b_level,
  output logic [7:0] out_port_b_drive,
  output logic [7:0] out_port_c_level,
  output logic [7:0] out_port_c_drive
);

  localparam int unsigned AW = $clog2(SLOT_COUNT);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_POST  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  tpbp_pkg::port_byte_t mask_r [tpbp_pkg::NUM_PORTS];
  tpbp_pkg::port_byte_t lvl_r  [tpbp_pkg::NUM_PORTS];
  logic       status_r;
  logic [1:0] port_r;
  logic [2:0] pin_r;

  logic       out_valid_r;
  logic       out_status_r;
  tpbp_pkg::port_byte_t out_lvl_r   [tpbp_pkg::NUM_PORTS];
  tpbp_pkg::port_byte_t out_drive_r [tpbp_pkg::NUM_PORTS];

  logic in_xfer;
  logic out_free;
  logic set_ok;
  logic set_bad;

  tpbp_pkg::store_ctl_t       store_ctl;
  tpbp_pkg::sweep_ctl_t       sweep_ctl;
  logic [AW-1:0]              sweep_idx;
  logic                       sweep_on;
  logic                       sweep_last;
  logic [tpbp_pkg::ROW_W-1:0] row_data;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Classify an incoming set-duty item.
  assign set_bad = (in_cmd == tpbp_pkg::CMD_SET_DUTY) && (in_port_index > tpbp_pkg::PORT_MAX);
  assign set_ok  = (in_cmd == tpbp_pkg::CMD_SET_DUTY) && !set_bad &&
                   (in_pin_index < tpbp_pkg::PIN_LIMIT);

  // Sequencer next state and unit controls.
  always_comb begin
    state_nxt         = state_r;
    sweep_ctl         = '0;
    store_ctl         = '0;
    store_ctl.bit_sel = {port_r, pin_r};
    store_ctl.bit_val = sweep_on;
    case (state_r)
      ST_CLEAR: begin
        store_ctl.clr  = 1'b1;
        sweep_ctl.step = 1'b1;
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == tpbp_pkg::CMD_TICK) begin
            store_ctl.rd = 1'b1;
            state_nxt    = ST_READ;
          end else if (set_ok) begin
            sweep_ctl.start = 1'b1;
            state_nxt       = ST_SWEEP;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_SWEEP: begin
        store_ctl.wr_bit = 1'b1;
        sweep_ctl.step   = 1'b1;
        if (sweep_last) begin
          state_nxt = ST_POST;
        end
      end
      ST_READ: begin
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Slot counter advances on each tick transfer and wraps.
  always_comb begin
    slot_nxt = slot_r;
    if (in_xfer && (in_cmd == tpbp_pkg::CMD_TICK)) begin
      slot_nxt = (slot_r == AW'(SLOT_COUNT - 1)) ? '0 : slot_r + AW'(1);
    end
  end

  // Control registers: state, slot, drive masks and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < tpbp_pkg::NUM_PORTS; p++) begin
        mask_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (in_xfer && set_ok) begin
        for (int p = 0; p < tpbp_pkg::NUM_PORTS; p++) begin
          if (in_port_index[1:0] == 2'(p)) begin
            mask_r[p] <= mask_r[p] | (8'd1 << in_pin_index[2:0]);
          end
        end
      end
      if ((state_r == ST_POST) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item fields and the pending result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      port_r   <= in_port_index[1:0];
      pin_r    <= in_pin_index[2:0];
      status_r <= set_bad ? tpbp_pkg::STATUS_BAD : tpbp_pkg::STATUS_OK;
      for (int p = 0; p < tpbp_pkg::NUM_PORTS; p++) begin
        lvl_r[p] <= '0;
      end
    end else if (state_r == ST_READ) begin
      for (int p = 0; p < tpbp_pkg::NUM_PORTS; p++) begin
        lvl_r[p] <= row_data[p*tpbp_pkg::PORT_W +: tpbp_pkg::PORT_W] & mask_r[p];
      end
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if ((state_r == ST_POST) && out_free) begin
      out_status_r <= status_r;
      for (int p = 0; p < tpbp_pkg::NUM_PORTS; p++) begin
        out_lvl_r[p]   <= lvl_r[p];
        out_drive_r[p] <= mask_r[p];
      end
    end
  end

  tpbp_sweep #(
    .SLOT_COUNT (SLOT_COUNT),
    .AW         (AW)
  ) u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sweep_ctl),
    .duty  (in_duty),
    .idx   (sweep_idx),
    .on    (sweep_on),
    .last  (sweep_last)
  );

  tpbp_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (store_ctl),
    .waddr (sweep_idx),
    .raddr (slot_r),
    .rdata (row_data)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_port_a_level = out_lvl_r[0];
  assign out_port_a_drive = out_drive_r[0];
  assign out_port_b_level = out_lvl_r[1];
  assign out_port_b_drive = out_drive_r[1];
  assign out_port_c_level = out_lvl_r[2];
  assign out_port_c_drive = out_drive_r[2];

endmodule : three_port_bitplane_pwm_unit

`default_nettype wire
